// File: hw/rtl/mvwo_pkg.sv
// ----------------------------------------------------------------------------
// mvwo_pkg
// Shared constants, codes, control types and the sine table generator for the
// multi-voice wavetable oscillator.
// ----------------------------------------------------------------------------
package mvwo_pkg;

  localparam int VOICES       = 16;
  localparam int TABLE_DEPTH  = 2048;
  localparam int SINE_ENTRIES = 1024;

  localparam int VoiceAw     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int TabAw       = $clog2(TABLE_DEPTH);
  localparam int SineAw      = $clog2(SINE_ENTRIES);
  localparam int SineQuarter = SINE_ENTRIES / 4;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [11:0] MaxCycle    = 12'd2048;
  localparam logic [11:0] ResetCycle  = 12'd2048;

  localparam logic [CfgIdxW-1:0] REG_WAVEFORM     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CYCLE_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TABLE_LENGTH = 2'd2;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SAW      = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_TABLE    = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic capture;
    logic phase;
    logic mul;
    logic rd0;
    logic rd1;
    logic interp;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip_table;
  } dp_status_t;

  // quarter-wave sine magnitude, Q1.15, taylor polynomial in Q30
  function automatic logic [15:0] sine_mag(input int j);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] mag;
    t   = 64'(j) * (Q30_ONE / 64'(SineQuarter));
    x   = (t * HALF_PI_Q30) >> 30;
    x2  = (x * x) >> 30;
    a   = Q30_ONE - x2 / 64'd72;
    a   = Q30_ONE - ((x2 * a) >> 30) / 64'd42;
    a   = Q30_ONE - ((x2 * a) >> 30) / 64'd20;
    a   = Q30_ONE - ((x2 * a) >> 30) / 64'd6;
    s   = (x * a) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (mag > 64'd32768) begin
      mag = 64'd32768;
    end
    return mag[15:0];
  endfunction

endpackage

// File: hw/rtl/multi_voice_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// multi_voice_wavetable_oscillator
// Phase accumulator oscillator for up to 16 voices with sine, triangle, saw,
// square and interpolated wave table outputs.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i/in_ready_o): a write item stores table_value_i
//   at table_addr_i and returns a zero sample; a tick item advances the
//   phase of voice_i (cleared first when restart_i is set) and returns one
//   waveform sample. every transfer on the input gives one output transfer.
//   output channel (out_valid_o/out_ready_i): sample_o, signed q1.15.
//   configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 waveform, 1 cycle_length, 2 table_length) in the same cycle; write
//   only while no item is in flight.
//   steps: writes and non-table waveforms run the phase and finish steps;
//   the table waveform adds the position multiply, the two sequential
//   reads of the single-port wave table and the interpolation multiply
//   between them. one item is in work at a time, so a new item is taken
//   only once the last one has left its finish step.
//   the next item is taken while a finished sample waits on the output; a
//   stalled receiver holds the second result in its final step.
//   reset: voice phases clear, waveform sine, cycle_length 2048,
//   table_length 0; the wave table is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module multi_voice_wavetable_oscillator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mvwo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mvwo_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [3:0]                     voice_i,
  input  logic                           restart_i,
  input  logic [31:0]                    phase_step_i,
  input  logic signed [15:0]             fm_offset_i,
  input  logic [10:0]                    table_addr_i,
  input  logic signed [15:0]             table_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             sample_o
);

  mvwo_pkg::ctrl_cmd_t  ctrl_cmd;
  mvwo_pkg::dp_status_t dp_status;

  mvwo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  mvwo_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .voice_i       (voice_i),
    .restart_i     (restart_i),
    .phase_step_i  (phase_step_i),
    .fm_offset_i   (fm_offset_i),
    .table_addr_i  (table_addr_i),
    .table_value_i (table_value_i),
    .ctrl_i        (ctrl_cmd),
    .status_o      (dp_status),
    .sample_o      (sample_o)
  );

endmodule

// File: hw/rtl/mvwo_ram.sv
// ----------------------------------------------------------------------------
// mvwo_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mvwo_ram #(
  parameter int DataWidth = 16,
  parameter int Depth     = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mvwo_ctrl.sv
// ----------------------------------------------------------------------------
// mvwo_ctrl
// Sequencer for one item at a time: phase update, table fetch and
// interpolation steps, and the output valid flag.
// ----------------------------------------------------------------------------
module mvwo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mvwo_pkg::dp_status_t  status_i,
  output mvwo_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_RD0   = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_INT   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd_o.phase = 1'b1;
        state_d     = status_i.skip_table ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RD0;
      end
      S_RD0: begin
        cmd_o.rd0 = 1'b1;
        state_d   = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d   = S_INT;
      end
      S_INT: begin
        cmd_o.interp = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_finish_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while output still held");

  a_accept_to_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PHASE))
    else $error("accepted item did not start phase step");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("output valid raised outside finish step");

  a_rd1_after_rd0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |-> ($past(state_q) == S_RD0))
    else $error("second table read without first");
`endif

endmodule

// File: hw/rtl/mvwo_dp.sv
// ----------------------------------------------------------------------------
// mvwo_dp
// Datapath: configuration registers, voice phase accumulators, wave table,
// interpolation arithmetic and waveform selection with the output register.
// ----------------------------------------------------------------------------
module mvwo_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mvwo_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mvwo_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             cmd_i,
  input  logic [3:0]                       voice_i,
  input  logic                             restart_i,
  input  logic [31:0]                      phase_step_i,
  input  logic signed [15:0]               fm_offset_i,
  input  logic [10:0]                      table_addr_i,
  input  logic signed [15:0]               table_value_i,
  input  mvwo_pkg::ctrl_cmd_t              ctrl_i,
  output mvwo_pkg::dp_status_t             status_o,
  output logic signed [15:0]               sample_o
);

  // configuration
  logic [2:0]  waveform_q;
  logic [11:0] cycle_length_q;
  logic [11:0] table_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q     <= mvwo_pkg::WAVE_SINE;
      cycle_length_q <= mvwo_pkg::ResetCycle;
      table_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mvwo_pkg::REG_WAVEFORM:     waveform_q     <= cfg_wdata_i[2:0];
        mvwo_pkg::REG_CYCLE_LENGTH: cycle_length_q <= cfg_wdata_i;
        mvwo_pkg::REG_TABLE_LENGTH: table_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // captured item
  logic               cmd_q;
  logic [3:0]         voice_q;
  logic               restart_q;
  logic [31:0]        step_q;
  logic [15:0]        fm_q;
  logic [10:0]        addr_q;
  logic [15:0]        value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q     <= cmd_i;
      voice_q   <= voice_i;
      restart_q <= restart_i;
      step_q    <= phase_step_i;
      fm_q      <= fm_offset_i;
      addr_q    <= table_addr_i;
      value_q   <= table_value_i;
    end
  end

  logic voice_ok;
  logic zero_res;
  assign voice_ok = (int'(voice_q) < mvwo_pkg::VOICES);
  assign zero_res = (cmd_q == mvwo_pkg::CMD_WRITE) || !voice_ok;
  assign status_o.skip_table = zero_res || (waveform_q != mvwo_pkg::WAVE_TABLE);

  // voice phase accumulators
  logic [31:0]                  phase_q [mvwo_pkg::VOICES];
  logic [mvwo_pkg::VoiceAw-1:0] vidx;
  logic [31:0]                  ph_new;
  logic [31:0]                  p_q;

  assign vidx   = mvwo_pkg::VoiceAw'(voice_q);
  assign ph_new = (restart_q ? 32'd0 : phase_q[vidx]) + step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < mvwo_pkg::VOICES; v++) begin
        phase_q[v] <= '0;
      end
    end else if (ctrl_i.phase && (cmd_q == mvwo_pkg::CMD_TICK) && voice_ok) begin
      phase_q[vidx] <= ph_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.phase) begin
      p_q <= ph_new + {fm_q, 16'd0};
    end
  end

  // table position
  logic [11:0] clen;
  logic [43:0] pos;
  logic [11:0] i0, i1, i0_inc;
  logic [11:0] i0_q, i1_q;
  logic [31:0] f_q;
  logic        v0_q, v1_q;

  always_comb begin
    clen = cycle_length_q;
    if (clen == 12'd0) begin
      clen = 12'd1;
    end else if (clen > mvwo_pkg::MaxCycle) begin
      clen = mvwo_pkg::MaxCycle;
    end
  end

  assign pos    = p_q * clen;
  assign i0     = pos[43:32];
  assign i0_inc = i0 + 12'd1;
  assign i1     = (i0_inc == clen) ? 12'd0 : i0_inc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      i0_q <= i0;
      i1_q <= i1;
      f_q  <= pos[31:0];
      v0_q <= (i0 < table_length_q) && (int'(i0) < mvwo_pkg::TABLE_DEPTH);
      v1_q <= (i1 < table_length_q) && (int'(i1) < mvwo_pkg::TABLE_DEPTH);
    end
  end

  // wave table
  logic                        ram_we;
  logic                        ram_re;
  logic [mvwo_pkg::TabAw-1:0]  ram_addr;
  logic [15:0]                 ram_rdata;

  assign ram_we = ctrl_i.phase && (cmd_q == mvwo_pkg::CMD_WRITE)
                  && (int'(addr_q) < mvwo_pkg::TABLE_DEPTH);
  assign ram_re = ctrl_i.rd0 || ctrl_i.rd1;

  always_comb begin
    if (ctrl_i.phase) begin
      ram_addr = mvwo_pkg::TabAw'(addr_q);
    end else if (ctrl_i.rd1) begin
      ram_addr = mvwo_pkg::TabAw'(i1_q);
    end else begin
      ram_addr = mvwo_pkg::TabAw'(i0_q);
    end
  end

  mvwo_ram #(
    .DataWidth (16),
    .Depth     (mvwo_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (value_q),
    .rdata_o (ram_rdata)
  );

  // interpolation
  logic signed [15:0] s0_q;
  logic signed [15:0] s1;
  logic signed [16:0] diff;
  logic signed [49:0] prod_q;
  logic signed [49:0] acc;
  logic signed [17:0] delta;
  logic signed [17:0] tab_sum;

  assign s1   = v1_q ? $signed(ram_rdata) : 16'sd0;
  assign diff = 17'(s1) - 17'(s0_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd1) begin
      s0_q <= v0_q ? $signed(ram_rdata) : 16'sd0;
    end
    if (ctrl_i.interp) begin
      prod_q <= 50'(diff) * $signed({1'b0, f_q});
    end
  end

  assign acc     = prod_q + 50'sd2147483648;
  assign delta   = acc[49:32];
  assign tab_sum = 18'(s0_q) + delta;

  // sine from quarter-wave table
  logic [15:0] sine_mag [mvwo_pkg::SineQuarter + 1];

  for (genvar g = 0; g <= mvwo_pkg::SineQuarter; g++) begin : g_sine
    localparam logic [15:0] Mag = mvwo_pkg::sine_mag(g);
    assign sine_mag[g] = Mag;
  end

  logic [mvwo_pkg::SineAw-1:0] sk;
  logic [mvwo_pkg::SineAw-2:0] sj;
  logic [15:0]                 smag;
  logic signed [15:0]          sine_v;

  assign sk   = p_q[31 -: mvwo_pkg::SineAw];
  assign sj   = sk[mvwo_pkg::SineAw-2] ?
                (mvwo_pkg::SineAw-1)'(mvwo_pkg::SineQuarter)
                - {1'b0, sk[mvwo_pkg::SineAw-3:0]}
                : {1'b0, sk[mvwo_pkg::SineAw-3:0]};
  assign smag = sine_mag[sj];

  always_comb begin
    if (sk[mvwo_pkg::SineAw-1]) begin
      sine_v = 16'(17'd0 - {1'b0, smag});
    end else if (smag > 16'd32767) begin
      sine_v = 16'sd32767;
    end else begin
      sine_v = smag;
    end
  end

  // triangle
  logic [31:0]        tri_d;
  logic signed [17:0] tri_v;
  logic signed [15:0] tri_s;

  assign tri_d = p_q[31] ? {1'b0, p_q[30:0]} : (32'h8000_0000 - p_q);
  assign tri_v = 18'sd32768 - $signed({1'b0, tri_d[31:15]});
  assign tri_s = (tri_v > 18'sd32767) ? 16'sd32767 : tri_v[15:0];

  // waveform select and output register
  logic signed [15:0] result;
  logic signed [15:0] sample_q;

  always_comb begin
    result = '0;
    if (!zero_res) begin
      case (waveform_q)
        mvwo_pkg::WAVE_SINE:     result = sine_v;
        mvwo_pkg::WAVE_TRIANGLE: result = tri_s;
        mvwo_pkg::WAVE_SAW:      result = {~p_q[31], p_q[30:16]};
        mvwo_pkg::WAVE_SQUARE:   result = p_q[31] ? 16'sh8000 : 16'sh7FFF;
        mvwo_pkg::WAVE_TABLE:    result = tab_sum[15:0];
        default:                 result = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      sample_q <= result;
    end
  end

  assign sample_o = sample_q;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the multi-voice wavetable oscillator against an in-bench predictor of
// the voice phases, the wave table and every waveform. A directed table covers
// the field extremes, each waveform and the corner cases of the table readout,
// a load of the low table entries follows, then random note sequences run
// under changing register settings and handshake idling, one phase with a long
// receiver hold.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mvwo_pkg::*;

  localparam int DIR_ROWS      = 32;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 118;
  localparam int LOAD_DEPTH    = 256;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_MAX     = 2048;

  localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam logic [2:0] WAVE_MUTE_LO = 3'd5;
  localparam logic [2:0] WAVE_MUTE_HI = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  voice;
    logic        restart;
    logic [31:0] step;
    logic [15:0] fm;
    logic [10:0] addr;
    logic [15:0] value;
  } osc_item_t;

  typedef struct packed {
    logic                is_reg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    osc_item_t           it;
    logic                typed;
    logic [15:0]         want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                cmd_i;
  logic [3:0]          voice_i;
  logic                restart_i;
  logic [31:0]         phase_step_i;
  logic signed [15:0]  fm_offset_i;
  logic [10:0]         table_addr_i;
  logic signed [15:0]  table_value_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [15:0]  sample_o;

  // predictor state
  logic [2:0]  wave_sel;
  logic [11:0] cyc_len;
  logic [11:0] tab_len;
  logic [31:0] voice_phase [VOICES];
  logic [15:0] wave_mem [TABLE_DEPTH];

  logic [15:0] pending_samples [$];
  int          mismatches = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  dir_row_t    dir_rows [DIR_ROWS];

  multi_voice_wavetable_oscillator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .voice_i      (voice_i),
    .restart_i    (restart_i),
    .phase_step_i (phase_step_i),
    .fm_offset_i  (fm_offset_i),
    .table_addr_i (table_addr_i),
    .table_value_i(table_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o)
  );

  always #5ns clk_i = ~clk_i;

  function automatic logic [15:0] sine_at(logic [63:0] k);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] mag;
    p   = (k << 32) / 64'(SINE_ENTRIES);
    r   = {34'd0, p[29:0]};
    t   = p[30] ? UNIT_Q30 - r : r;
    x   = (t * QUARTER_TURN_Q30) >> 30;
    x2  = (x * x) >> 30;
    a   = UNIT_Q30 - x2 / 64'd72;
    a   = UNIT_Q30 - ((x2 * a) >> 30) / 64'd42;
    a   = UNIT_Q30 - ((x2 * a) >> 30) / 64'd20;
    a   = UNIT_Q30 - ((x2 * a) >> 30) / 64'd6;
    s   = (x * a) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (p[31]) begin
      return (mag > 64'd32768) ? 16'h8000 : 16'(64'd0 - mag);
    end
    return (mag > 64'd32767) ? 16'h7fff : mag[15:0];
  endfunction

  function automatic logic [15:0] wave_at(logic [31:0] p);
    int          c;
    int          i0;
    int          i1;
    int          s0;
    int          s1;
    int          v;
    logic [63:0] pos;
    longint      acc;
    case (wave_sel)
      WAVE_SINE: begin
        return sine_at((64'(p) * 64'(SINE_ENTRIES)) >> 32);
      end
      WAVE_TRIANGLE: begin
        v = 32768 - int'((p[31] ? p - 32'h8000_0000 : 32'h8000_0000 - p) >> 15);
        return (v > 32767) ? 16'h7fff : 16'(v);
      end
      WAVE_SAW: begin
        return {~p[31], p[30:16]};
      end
      WAVE_SQUARE: begin
        return p[31] ? 16'h8000 : 16'h7fff;
      end
      WAVE_TABLE: begin
        if (tab_len == 12'd0) begin
          return 16'd0;
        end
        c = int'(cyc_len);
        if (c < 1) begin
          c = 1;
        end
        if (c > CYCLE_MAX) begin
          c = CYCLE_MAX;
        end
        pos = 64'(p) * 64'(c);
        i0  = int'(pos[63:32]);
        i1  = (i0 + 1) % c;
        s0  = (i0 < int'(tab_len) && i0 < TABLE_DEPTH) ? int'($signed(wave_mem[i0])) : 0;
        s1  = (i1 < int'(tab_len) && i1 < TABLE_DEPTH) ? int'($signed(wave_mem[i1])) : 0;
        acc = longint'(s1 - s0) * longint'(pos[31:0]) + 64'sd2147483648;
        v   = s0 + int'(acc >>> 32);
        return 16'(v);
      end
      default: begin
        return 16'd0;
      end
    endcase
  endfunction

  function automatic logic [15:0] next_sample(osc_item_t it);
    logic [31:0] ph;
    if (it.cmd == CMD_WRITE) begin
      if (int'(it.addr) < TABLE_DEPTH) begin
        wave_mem[it.addr] = it.value;
      end
      return 16'd0;
    end
    if (int'(it.voice) >= VOICES) begin
      return 16'd0;
    end
    ph = it.restart ? 32'd0 : voice_phase[it.voice];
    ph = ph + it.step;
    voice_phase[it.voice] = ph;
    return wave_at(ph + {it.fm, 16'd0});
  endfunction

  function automatic osc_item_t random_item();
    osc_item_t it;
    it.cmd     = 1'($urandom);
    it.voice   = 4'($urandom);
    it.restart = 1'($urandom);
    it.step    = $urandom;
    it.fm      = 16'($urandom);
    it.addr    = 11'($urandom);
    it.value   = 16'($urandom);
    return it;
  endfunction

  function automatic dir_row_t tick_row(logic [3:0] v, logic rs, logic [31:0] st,
                                        logic [15:0] fm, logic typed, logic [15:0] want);
    dir_row_t r;
    r            = '0;
    r.it.cmd     = CMD_TICK;
    r.it.voice   = v;
    r.it.restart = rs;
    r.it.step    = st;
    r.it.fm      = fm;
    r.typed      = typed;
    r.want       = want;
    return r;
  endfunction

  function automatic dir_row_t load_row(logic [10:0] addr, logic [15:0] value);
    dir_row_t r;
    r          = '0;
    r.it.cmd   = CMD_WRITE;
    r.it.addr  = addr;
    r.it.value = value;
    r.typed    = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    dir_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input osc_item_t it, input logic typed, input logic [15:0] want);
    logic [15:0] got;
    while ($urandom_range(99) < send_gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    voice_i       <= it.voice;
    restart_i     <= it.restart;
    phase_step_i  <= it.step;
    fm_offset_i   <= it.fm;
    table_addr_i  <= it.addr;
    table_value_i <= it.value;
    do @(posedge clk_i); while (!in_ready_o);
    got = next_sample(it);
    pending_samples.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WAVEFORM:     wave_sel = val[2:0];
      REG_CYCLE_LENGTH: cyc_len = val;
      REG_TABLE_LENGTH: tab_len = val;
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", sample_o));
      end else begin
        if (sample_o !== pending_samples[0]) begin
          report_mismatch($sformatf("sample %0d, expected %0d", sample_o,
                                    $signed(pending_samples[0])));
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  initial begin
    #10ms;
    $display("multi_voice_wavetable_oscillator test failed");
    $finish;
  end

  initial begin
    osc_item_t   it;
    logic [3:0]  note_voice;
    logic [31:0] note_step;
    logic [2:0]  wsel;
    logic [11:0] clen;
    logic [11:0] tlen;
    int          pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_WRITE;
    voice_i       = '0;
    restart_i     = 1'b0;
    phase_step_i  = '0;
    fm_offset_i   = '0;
    table_addr_i  = '0;
    table_value_i = '0;
    wave_sel      = WAVE_SINE;
    cyc_len       = 12'd2048;
    tab_len       = 12'd0;
    foreach (voice_phase[v]) begin
      voice_phase[v] = 32'd0;
    end
    note_voice = 4'd0;
    note_step  = 32'h0100_0000;

    dir_rows = '{
      tick_row(4'd0,  1'b1, 32'h0000_0000, 16'h0000, 1'b1, 16'h0000),
      tick_row(4'd15, 1'b0, 32'h4000_0000, 16'h0000, 1'b0, 16'h0000),
      tick_row(4'd1,  1'b1, 32'hC000_0000, 16'h0000, 1'b0, 16'h0000),
      load_row(11'd0,    16'h7fff),
      load_row(11'd1,    16'h8000),
      load_row(11'd2047, 16'h1234),
      reg_row(REG_WAVEFORM, 12'(WAVE_TRIANGLE)),
      tick_row(4'd3,  1'b1, 32'h0000_0000, 16'h8000, 1'b1, 16'h7fff),
      tick_row(4'd3,  1'b1, 32'h0000_0000, 16'h0000, 1'b1, 16'h8000),
      reg_row(REG_WAVEFORM, 12'(WAVE_SAW)),
      tick_row(4'd4,  1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b1, 16'h7fff),
      tick_row(4'd4,  1'b0, 32'h0000_0001, 16'h0000, 1'b1, 16'h8000),
      reg_row(REG_WAVEFORM, 12'(WAVE_SQUARE)),
      reg_row(REG_SPARE, 12'hFFF),
      tick_row(4'd5,  1'b1, 32'h7FFF_FFFF, 16'h0000, 1'b1, 16'h7fff),
      tick_row(4'd5,  1'b0, 32'h0000_0001, 16'h7FFF, 1'b1, 16'h8000),
      reg_row(REG_WAVEFORM, 12'(WAVE_TABLE)),
      tick_row(4'd6,  1'b1, 32'h1234_5678, 16'h0000, 1'b1, 16'h0000),
      reg_row(REG_TABLE_LENGTH, 12'd2),
      reg_row(REG_CYCLE_LENGTH, 12'd2),
      tick_row(4'd7,  1'b1, 32'h0000_0000, 16'h0000, 1'b1, 16'h7fff),
      tick_row(4'd7,  1'b0, 32'h4000_0000, 16'h0000, 1'b0, 16'h0000),
      tick_row(4'd7,  1'b0, 32'h8000_0000, 16'h0000, 1'b0, 16'h0000),
      reg_row(REG_CYCLE_LENGTH, 12'd0),
      tick_row(4'd8,  1'b1, 32'h9000_0000, 16'h0000, 1'b1, 16'h7fff),
      reg_row(REG_CYCLE_LENGTH, 12'hFFF),
      tick_row(4'd9,  1'b1, 32'h0000_0000, 16'h0010, 1'b0, 16'h0000),
      tick_row(4'd9,  1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'h0000),
      reg_row(REG_WAVEFORM, 12'(WAVE_MUTE_LO)),
      tick_row(4'd10, 1'b1, 32'h8000_0000, 16'h0000, 1'b1, 16'h0000),
      reg_row(REG_WAVEFORM, 12'(WAVE_MUTE_HI)),
      tick_row(4'd11, 1'b1, 32'h0000_0001, 16'h0000, 1'b1, 16'h0000)
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_gap   = 17;
    recv_stall = 17;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // load the low entries, table reads stay below LOAD_DEPTH from here on
    for (int a = 0; a < LOAD_DEPTH; a++) begin
      it      = random_item();
      it.cmd  = CMD_WRITE;
      it.addr = 11'(a);
      send_item(it, 1'b0, 16'd0);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin wsel = WAVE_SINE;     clen = 12'd2048; tlen = 12'd2048; end
        1: begin wsel = WAVE_TRIANGLE; clen = 12'd2048; tlen = 12'd0;    end
        2: begin wsel = WAVE_SAW;      clen = 12'd1;    tlen = 12'd1;    end
        3: begin wsel = WAVE_SQUARE;   clen = 12'd0;    tlen = 12'hFFF;  end
        4: begin wsel = WAVE_TABLE;    clen = 12'd2048; tlen = 12'(LOAD_DEPTH); end
        5: begin wsel = WAVE_TABLE;    clen = 12'd1;    tlen = 12'd2048; end
        6: begin wsel = WAVE_TABLE;    clen = 12'd0;    tlen = 12'hFFF;  end
        7: begin wsel = WAVE_TABLE;    clen = 12'hFFF;  tlen = 12'd200;  end
        8: begin wsel = WAVE_TABLE;    clen = 12'd3;    tlen = 12'd2;    end
        9: begin
          wsel = WAVE_TABLE;
          clen = 12'($urandom_range(CYCLE_MAX, 1));
          tlen = 12'($urandom_range(TABLE_DEPTH, 0));
        end
        10: begin
          wsel = 3'($urandom_range(WAVE_MUTE_HI, WAVE_MUTE_LO));
          clen = 12'($urandom);
          tlen = 12'($urandom);
        end
        default: begin
          wsel = 3'($urandom);
          clen = 12'($urandom);
          tlen = 12'($urandom);
        end
      endcase
      // keep table reads inside the loaded entries
      if (wsel == WAVE_TABLE && clen > 12'(LOAD_DEPTH) && tlen > 12'(LOAD_DEPTH)) begin
        tlen = 12'($urandom_range(LOAD_DEPTH, 0));
      end
      write_reg(REG_WAVEFORM, 12'(wsel));
      write_reg(REG_CYCLE_LENGTH, clen);
      write_reg(REG_TABLE_LENGTH, tlen);

      case (ph % 4)
        0:       begin send_gap = 0;  recv_stall = 0;  end
        1:       begin send_gap = 54; recv_stall = 0;  end
        2:       begin send_gap = 0;  recv_stall = 54; end
        default: begin send_gap = 17; recv_stall = 17; end
      endcase
      // long receiver hold while the sender keeps pushing
      if (ph == 4) begin
        hold_req = 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it   = random_item();
        pick = $urandom_range(99);
        if (pick < 10) begin
          note_voice = it.voice;
          note_step  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0200_0000);
          it.cmd     = CMD_TICK;
          it.restart = 1'b1;
          it.step    = note_step;
        end else if (pick < 75) begin
          it.cmd     = CMD_TICK;
          it.voice   = note_voice;
          it.restart = 1'b0;
          it.step    = note_step;
        end else if (pick < 90) begin
          it.cmd = CMD_WRITE;
        end
        if ($urandom_range(1) == 0) begin
          it.fm = 16'd0;
        end
        send_item(it, 1'b0, 16'd0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("multi_voice_wavetable_oscillator test passed");
    end else begin
      $display("multi_voice_wavetable_oscillator test failed");
    end
    $finish;
  end

endmodule
